// ===== rtl/core/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, opcodes and controller/datapath interface types for the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int OpW        = 3;
  localparam int PosW       = 6;
  localparam int DataW      = 32;
  localparam int OccW       = 7;
  localparam int MaxResults = 64;

  localparam logic [OpW-1:0] OP_READ     = 3'd0;
  localparam logic [OpW-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OpW-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE   = 3'd3;
  localparam logic [OpW-1:0] OP_DUMP     = 3'd4;

  // Source of the data field of an emitted result
  typedef enum logic [1:0] {
    EMIT_ZERO,
    EMIT_FAIL,
    EMIT_MEM
  } emit_sel_e;

  // Memory write kinds
  typedef enum logic [1:0] {
    WR_NONE,
    WR_HEAD,
    WR_TAIL,
    WR_SHIFT
  } wr_sel_e;

  typedef struct packed {
    logic      capture;
    logic      rd_en;
    logic      rd_next;
    wr_sel_e   wr_sel;
    logic      cur_clr;
    logic      cur_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_ok;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           pos_hit;
    logic           full;
    logic           empty;
    logic           shift_done;
    logic           dump_last;
    logic           out_free;
  } sts_t;

endpackage

// ===== rtl/core/ordered_list_engine_core.sv =====
// Accept to result valid: inserts, failed operations and last-entry removal
// emit from the execute step, a read after one memory read, a remove after a
// read/write pair per later entry moved; a dump reads, then emits, each beat.
// One item in flight; the next is taken in the cycle after the last beat is
// loaded. The one-access-per-cycle memory sets the steps; output stalls add.
// Reset clears control state, head, count and result valid, not the memory.
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded ordered list of signed 32-bit values: read, insert at head or
// tail, remove with gap closing, and in-order dump.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ole_pkg::OpW-1:0]          opcode_i,
  input  logic [ole_pkg::PosW-1:0]         position_i,
  input  logic signed [ole_pkg::DataW-1:0] data_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic signed [ole_pkg::DataW-1:0] data_out_o,
  output logic                             last_o,
  output logic [ole_pkg::OccW-1:0]         occupancy_o
);
  import ole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ole_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .data_out_o  (data_out_o),
    .last_o      (last_o),
    .occupancy_o (occupancy_o)
  );

  // a result beat is only loaded when the output slot can take it
  a_emit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // no insert write when the list is full
  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_sel == WR_HEAD || cmd.wr_sel == WR_TAIL) |-> !sts.full)
    else $error("insert written into a full list");

  // one item at a time: an accepted beat blocks the input next cycle
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // removal commit only after the gap is closed
  a_remove_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> (sts.pos_hit && sts.shift_done && !sts.empty))
    else $error("count dropped before shift sweep finished");

endmodule

// ===== rtl/core/ole_ctrl.sv =====
// ----------------------------------------------------------------------------
// ole_ctrl
// Operation sequencer: decodes the captured opcode and steps the datapath
// through reads, writes, shift sweeps and dump beats.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ole_pkg::sts_t sts_i,
  output ole_pkg::cmd_t cmd_o
);
  import ole_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_EMRD = 3'd5;

  logic [2:0] state_q, state_d;
  logic       rd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign rd_last    = (sts_i.op == OP_READ) || sts_i.dump_last;

  always_comb begin
    state_d         = state_q;
    cmd_o.capture   = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_next   = 1'b0;
    cmd_o.wr_sel    = WR_NONE;
    cmd_o.cur_clr   = 1'b0;
    cmd_o.cur_inc   = 1'b0;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.cnt_dec   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_sel  = EMIT_ZERO;
    cmd_o.emit_ok   = 1'b0;
    cmd_o.emit_last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op) inside
          OP_READ: begin
            if (sts_i.pos_hit) begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_EMRD;
            end else if (sts_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = EMIT_FAIL;
              state_d        = S_IDLE;
            end
          end
          OP_INS_HEAD, OP_INS_TAIL: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              if (!sts_i.full) begin
                cmd_o.wr_sel  = (sts_i.op == OP_INS_HEAD) ? WR_HEAD : WR_TAIL;
                cmd_o.cnt_inc = 1'b1;
                cmd_o.emit_ok = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (sts_i.pos_hit && !sts_i.shift_done) begin
              state_d = S_SHRD;
            end else if (sts_i.out_free) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_ok = sts_i.pos_hit;
              cmd_o.cnt_dec = sts_i.pos_hit;
              state_d       = S_IDLE;
            end
          end
          OP_DUMP: begin
            if (!sts_i.empty) begin
              cmd_o.cur_clr = 1'b1;
              state_d       = S_DRD;
            end else if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      // close the gap one entry per read/write pair
      S_SHRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.cur_inc = 1'b1;
        state_d       = S_EXEC;
      end
      S_DRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMRD;
      end
      S_EMRD: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_MEM;
          cmd_o.emit_ok   = 1'b1;
          cmd_o.emit_last = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cur_inc = 1'b1;
            state_d       = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ole_dpath.sv =====
// ----------------------------------------------------------------------------
// ole_dpath
// List storage as a circular buffer in a single-port style memory, with head
// pointer, entry count, cursor, and the registered result beat.
// ----------------------------------------------------------------------------
module ole_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ole_pkg::OpW-1:0]            opcode_i,
  input  logic [ole_pkg::PosW-1:0]           position_i,
  input  logic signed [ole_pkg::DataW-1:0]   data_in_i,
  input  ole_pkg::cmd_t                      cmd_i,
  output ole_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic signed [ole_pkg::DataW-1:0]   data_out_o,
  output logic                               last_o,
  output logic [ole_pkg::OccW-1:0]           occupancy_o
);
  import ole_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int LW   = (CW + 1 > OccW) ? CW + 1 : OccW;
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  logic [DataW-1:0] mem_q [CAPACITY];
  logic [DataW-1:0] rdata_q;

  logic [AW-1:0]    hd_q, hd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cur_q;
  logic [OpW-1:0]   op_q;
  logic [PosW-1:0]  pos_q;
  logic [DataW-1:0] val_q;

  logic             out_valid_q;
  logic             ok_q, last_q;
  logic [DataW-1:0] data_q;
  logic [OccW-1:0]  occ_q;

  logic [LW-1:0]    cur_nx;
  logic [AW-1:0]    hd_dec;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [DataW-1:0] wr_data;
  logic             wr_en;
  logic             out_free;

  // logical index -> memory address, wrapping once past the end
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, hd} + (AW+1)'(idx);
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign cur_nx   = LW'(cur_q) + LW'(1);
  assign hd_dec   = (hd_q == '0) ? AW'(CAPACITY - 1) : hd_q - AW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.op         = op_q;
  assign sts_o.pos_hit    = CMPW'(pos_q) < CMPW'(cnt_q);
  assign sts_o.full       = (cnt_q == CW'(CAPACITY));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.shift_done = (cur_nx >= LW'(cnt_q));
  assign sts_o.dump_last  = (cur_nx == LW'(cnt_q)) || (cur_nx == LW'(MaxResults));
  assign sts_o.out_free   = out_free;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    hd_d    = hd_q;
    wr_en   = 1'b1;
    wr_addr = phys(hd_q, cur_q);
    wr_data = rdata_q;
    unique case (cmd_i.wr_sel)
      WR_HEAD: begin
        hd_d    = hd_dec;
        wr_addr = hd_dec;
        wr_data = val_q;
      end
      WR_TAIL: begin
        wr_addr = phys(hd_q, cnt_q);
        wr_data = val_q;
      end
      WR_SHIFT: begin
        wr_addr = phys(hd_q, cur_q);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd_i.rd_next ? phys(hd_q, cur_nx[CW-1:0]) : phys(hd_q, cur_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hd_q  <= hd_d;
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= data_in_i;
      cur_q <= CW'(position_i);
    end else if (cmd_i.cur_clr) begin
      cur_q <= '0;
    end else if (cmd_i.cur_inc) begin
      cur_q <= cur_nx[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ok_q   <= cmd_i.emit_ok;
      last_q <= cmd_i.emit_last;
      occ_q  <= OccW'(cnt_d);
      case (cmd_i.emit_sel)
        EMIT_MEM:  data_q <= rdata_q;
        EMIT_FAIL: data_q <= '1;
        default:   data_q <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = data_q;
  assign last_o      = last_q;
  assign occupancy_o = occ_q;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ordered_list_engine_core. A queue of list operations
// feeds the input channel with random gaps. Expected beats are computed from a
// shadow copy of the list when each operation is accepted. The output channel
// is stalled at random, and every beat is compared with the oldest expected
// one. The random part fills the list to capacity, works it while full, and
// then shrinks it with mostly removals.
// ----------------------------------------------------------------------------
module tb;
  import ole_pkg::*;

  localparam int Capacity    = 64;
  localparam int RandItems   = 128;
  localparam int FullItems   = 14;
  localparam int MaxIdle     = 6;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 200;
  localparam int ReportMax   = 10;

  // opcodes the block rejects
  localparam logic [OpW-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_BAD_LAST  = 3'd7;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_FULL,
    MIX_SHRINK
  } mix_e;

  typedef struct {
    logic [OpW-1:0]          op;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } list_op_t;

  typedef struct {
    logic                    ok;
    logic signed [DataW-1:0] data;
    logic                    last;
    logic [OccW-1:0]         occ;
  } list_beat_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [OpW-1:0]          opcode_i    = '0;
  logic [PosW-1:0]         position_i  = '0;
  logic signed [DataW-1:0] data_in_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    ok_o;
  logic signed [DataW-1:0] data_out_o;
  logic                    last_o;
  logic [OccW-1:0]         occupancy_o;

  ordered_list_engine_core #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .data_out_o (data_out_o),
    .last_o     (last_o),
    .occupancy_o(occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  list_op_t   pending_ops[$];
  list_op_t   cur_op;
  list_beat_t expected_beats[$];

  // shadow list, updated on every accepted operation
  logic signed [DataW-1:0] list_mem[Capacity];
  int unsigned             list_len = 0;

  int unsigned plan_len       = 0;
  int          idle_left      = 0;
  int          stall_left     = 0;
  int          stall_draw     = 0;
  int          in_quiet       = 0;
  int          out_quiet      = 0;
  int          quiet_cycles   = 0;
  int          beats_expected = 0;
  int          beats_seen     = 0;
  int          mismatches     = 0;
  bit          all_sent       = 1'b0;

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void push_beat(logic ok, logic signed [DataW-1:0] data, logic last);
    list_beat_t b;
    b.ok   = ok;
    b.data = data;
    b.last = last;
    b.occ  = list_len[OccW-1:0];
    expected_beats = {expected_beats, b};
    beats_expected++;
  endfunction

  function automatic void apply_list_op(list_op_t it);
    int unsigned n;
    case (it.op) inside
      OP_READ: begin
        if (it.pos < list_len) push_beat(1'b1, list_mem[it.pos], 1'b1);
        else push_beat(1'b0, -1, 1'b1);
      end
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (list_len >= Capacity) begin
          push_beat(1'b0, 0, 1'b1);
        end else begin
          if (it.op == OP_INS_HEAD) begin
            for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
            list_mem[0] = it.value;
          end else begin
            list_mem[list_len] = it.value;
          end
          list_len++;
          push_beat(1'b1, 0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (it.pos >= list_len) begin
          push_beat(1'b0, 0, 1'b1);
        end else begin
          for (int i = it.pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          push_beat(1'b1, 0, 1'b1);
        end
      end
      OP_DUMP: begin
        n = (list_len > MaxResults) ? MaxResults : list_len;
        if (n == 0) push_beat(1'b0, 0, 1'b1);
        for (int i = 0; i < n; i++) push_beat(1'b1, list_mem[i], (i + 1 == n));
      end
      default: push_beat(1'b0, 0, 1'b1);
    endcase
  endfunction

  function automatic void check_beat();
    list_beat_t e;
    if (expected_beats.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat ok=%0b data=%0d last=%0b occ=%0d",
                              ok_o, data_out_o, last_o, occupancy_o));
      return;
    end
    e = expected_beats.pop_front();
    beats_seen++;
    if (ok_o !== e.ok || data_out_o !== e.data || last_o !== e.last ||
        occupancy_o !== e.occ)
      flag_mismatch($sformatf(
        "beat %0d expected ok=%0b data=%0d last=%0b occ=%0d, got ok=%0b data=%0d last=%0b occ=%0d",
        beats_seen, e.ok, e.data, e.last, e.occ, ok_o, data_out_o, last_o, occupancy_o));
  endfunction

  // idle cycles before the next beat, with occasional runs of back-to-back beats
  function automatic int next_idle(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(8, 30);
    return $urandom_range(0, MaxIdle);
  endfunction

  function automatic void add_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                 logic signed [DataW-1:0] value);
    list_op_t it;
    it.op    = op;
    it.pos   = pos;
    it.value = value;
    pending_ops = {pending_ops, it};
    if ((op == OP_INS_HEAD || op == OP_INS_TAIL) && plan_len < Capacity) plan_len++;
    else if (op == OP_REMOVE && pos < plan_len) plan_len--;
  endfunction

  function automatic logic [OpW-1:0] pick_opcode(int unsigned ins, int unsigned rd,
                                                 int unsigned rm, int unsigned dmp);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins) return $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
    if (roll < ins + rd) return OP_READ;
    if (roll < ins + rd + rm) return OP_REMOVE;
    if (roll < ins + rd + rm + dmp) return OP_DUMP;
    return OpW'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
  endfunction

  // mostly valid indexes, some anywhere in the field
  function automatic logic [PosW-1:0] pick_pos();
    if (plan_len > 0 && $urandom_range(0, 9) < 8)
      return PosW'($urandom_range(0, plan_len - 1));
    return PosW'($urandom_range(0, (1 << PosW) - 1));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return -1;
      3:       return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_random_ops();
    mix_e        mix;
    int unsigned held;
    mix  = MIX_GROW;
    held = 0;
    for (int n = 0; n < RandItems; n++) begin
      case (mix)
        MIX_GROW:   add_op(pick_opcode(80, 8, 4, 4), pick_pos(), pick_value());
        MIX_FULL:   add_op(pick_opcode(45, 25, 10, 10), pick_pos(), pick_value());
        default:    add_op(pick_opcode(8, 12, 70, 5), pick_pos(), pick_value());
      endcase
      if (mix == MIX_GROW && plan_len == Capacity) mix = MIX_FULL;
      else if (mix == MIX_FULL) begin
        held++;
        if (held == FullItems) mix = MIX_SHRINK;
      end
    end
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_list_op(cur_op);
        if (pending_ops.size() == 0) all_sent = 1'b1;
      end
      // a stalled beat holds its payload
      if (!(in_valid_i && in_stall_o)) begin
        if (idle_left > 0) begin
          idle_left  <= idle_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op      = pending_ops.pop_front();
          opcode_i   <= cur_op.op;
          position_i <= cur_op.pos;
          data_in_i  <= cur_op.value;
          in_valid_i <= 1'b1;
          idle_left  <= next_idle(in_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      check_beat();
      stall_draw = next_idle(out_quiet);
      stall_left  <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // empty list: dump, read and remove all fail
    add_op(OP_DUMP, 6'd0, 0);
    add_op(OP_READ, 6'd0, 0);
    add_op(OP_REMOVE, 6'd0, 0);
    add_op(OP_BAD_FIRST, 6'h3F, 32'h7FFF_FFFF);
    add_op(OP_BAD_FIRST + 3'd1, 6'h2A, 32'h8000_0000);
    add_op(OP_BAD_LAST, 6'h15, -1);
    add_op(OP_INS_HEAD, 6'h3F, 32'h7FFF_FFFF);
    add_op(OP_INS_TAIL, 6'h3F, 32'h8000_0000);
    add_op(OP_INS_HEAD, 6'd0, -1);
    add_op(OP_INS_TAIL, 6'd0, 0);
    add_op(OP_READ, 6'd0, 0);
    add_op(OP_READ, 6'd1, 0);
    add_op(OP_READ, 6'd2, 0);
    add_op(OP_READ, 6'd3, 0);
    add_op(OP_READ, 6'd4, 0);
    add_op(OP_READ, 6'h3F, 0);
    add_op(OP_DUMP, 6'd0, 0);
    // middle, tail, then head removal
    add_op(OP_REMOVE, 6'd1, 0);
    add_op(OP_REMOVE, 6'd2, 0);
    add_op(OP_REMOVE, 6'd0, 0);
    add_op(OP_READ, 6'd0, 0);
    add_op(OP_DUMP, 6'd0, 0);
    add_op(OP_REMOVE, 6'h3F, 0);
    queue_random_ops();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (all_sent && beats_seen == beats_expected);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ole_pkg.sv
rtl/core/ole_ctrl.sv
rtl/core/ole_dpath.sv
rtl/core/ordered_list_engine_core.sv
sim/tb.sv
